[hdl/ftc_pkg.sv]
// Shared types and constants for the frustum triangle clipper.
// Used by frustum_triangle_clipper_core and ftc_divider; depends on nothing.
`default_nettype none
package ftc_pkg;

	localparam int COORD_W     = 21;
	localparam int UV_W        = 16;
	localparam int DOT_W       = 40;
	localparam int MAG_W       = 39;
	localparam int PROD_W      = 60;
	localparam int QUO_W       = 22;
	localparam int NUM_LO_W    = 20;
	localparam int MUL_A_W     = 23;
	localparam int MUL_B_W     = 21;
	localparam int MUL_P_W     = 44;
	localparam int NORM_W      = 17;
	localparam int CFG_W       = 20;
	localparam int TRIG_W      = 16;
	localparam int IDX_W       = 3;
	localparam int PLANE_W     = 3;
	localparam int PLANE_COUNT = 6;

	localparam logic signed [NORM_W-1:0] NORMAL_ONE = 17'sd32768;

	// register indexes on the write port
	localparam logic [IDX_W-1:0] REG_NEAR = 3'd0;
	localparam logic [IDX_W-1:0] REG_FAR  = 3'd1;
	localparam logic [IDX_W-1:0] REG_VCOS = 3'd2;
	localparam logic [IDX_W-1:0] REG_VSIN = 3'd3;
	localparam logic [IDX_W-1:0] REG_HCOS = 3'd4;
	localparam logic [IDX_W-1:0] REG_HSIN = 3'd5;

	// plane order
	localparam logic [PLANE_W-1:0] PL_NEAR   = 3'd0;
	localparam logic [PLANE_W-1:0] PL_FAR    = 3'd1;
	localparam logic [PLANE_W-1:0] PL_TOP    = 3'd2;
	localparam logic [PLANE_W-1:0] PL_BOTTOM = 3'd3;
	localparam logic [PLANE_W-1:0] PL_LEFT   = 3'd4;
	localparam logic [PLANE_W-1:0] PL_RIGHT  = 3'd5;

	// component selects for crossing-point interpolation
	localparam logic [2:0] VAL_X = 3'd0;
	localparam logic [2:0] VAL_Y = 3'd1;
	localparam logic [2:0] VAL_Z = 3'd2;
	localparam logic [2:0] VAL_U = 3'd3;
	localparam logic [2:0] VAL_V = 3'd4;

	// inside codes, bit i set when vertex i is inside
	localparam logic [2:0] CODE_NONE = 3'b000;
	localparam logic [2:0] CODE_A    = 3'b001;
	localparam logic [2:0] CODE_B    = 3'b010;
	localparam logic [2:0] CODE_AB   = 3'b011;
	localparam logic [2:0] CODE_C    = 3'b100;
	localparam logic [2:0] CODE_AC   = 3'b101;
	localparam logic [2:0] CODE_BC   = 3'b110;
	localparam logic [2:0] CODE_ALL  = 3'b111;

	localparam logic [5:0] EDGE_AB = 6'h09;
	localparam logic [5:0] EDGE_BC = 6'h12;
	localparam logic [5:0] EDGE_CA = 6'h24;

	typedef struct packed {
		logic signed [UV_W-1:0]    v;
		logic signed [UV_W-1:0]    u;
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} vtx_t;

	typedef struct packed {
		vtx_t [2:0]         v;
		logic [5:0]         edges;
		logic [PLANE_W-1:0] plane;
	} tri_t;

endpackage
`default_nettype wire

[hdl/ftc_divider.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on ftc_pkg for widths. Quotient must fit in QUO_W bits.
`default_nettype none
module ftc_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ftc_pkg::PROD_W-1:0]    dividend,
	input  wire logic [ftc_pkg::MAG_W-1:0]     divisor,
	output logic      [ftc_pkg::QUO_W-1:0]     quotient,
	output logic                               done
);

	localparam int CW = $clog2(ftc_pkg::QUO_W + 1);

	logic                         busy_q;
	logic                         done_q;
	logic [CW-1:0]                cnt_q;
	logic [ftc_pkg::MAG_W-1:0]    rem_q;
	logic [ftc_pkg::QUO_W-1:0]    low_q;
	logic [ftc_pkg::QUO_W-1:0]    quo_q;
	logic [ftc_pkg::MAG_W:0]      trial;
	logic                         ge;

	assign trial = {rem_q, low_q[ftc_pkg::QUO_W-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(ftc_pkg::QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// top bits are below the divisor since the quotient fits QUO_W
			rem_q <= ftc_pkg::MAG_W'(dividend[ftc_pkg::PROD_W-1:ftc_pkg::QUO_W]);
			low_q <= dividend[ftc_pkg::QUO_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? ftc_pkg::MAG_W'(trial - {1'b0, divisor})
			            : trial[ftc_pkg::MAG_W-1:0];
			low_q <= {low_q[ftc_pkg::QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[ftc_pkg::QUO_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

[hdl/frustum_triangle_clipper_core.sv]
// Frustum triangle clipper top level: sequencer, shared multiplier, pending stack.
// Depends on ftc_pkg and ftc_divider.
//
// Clips one triangle against near, far, top, bottom, left and right planes and
// returns every surviving piece in depth-first order, the final one marked with
// last_piece; a fully clipped triangle gives one beat with none_visible set.
// Input is taken only while the block is idle. Each plane pass over a triangle
// forms nine products through the one shared multiplier, then classifies the
// vertices; each cut plane adds two crossing points of five components, each a
// two-part multiply and a 22-step division in the shared divider (a component
// whose denominator is zero is copied from the cut edge's first vertex). Run time
// for heavy clipping grows with the number of pieces. At most MAX_PIECES pieces
// are returned. An emitted piece is held back until the next piece or the end
// of the item shows whether it is the last one.
`default_nettype none
module frustum_triangle_clipper_core #(
	parameter int MAX_PIECES = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [62:0]                   vertex_a,
	input  wire logic [62:0]                   vertex_b,
	input  wire logic [62:0]                   vertex_c,
	input  wire logic [31:0]                   texcoord_a,
	input  wire logic [31:0]                   texcoord_b,
	input  wire logic [31:0]                   texcoord_c,
	input  wire logic [5:0]                    edge_flags,
	input  wire logic [15:0]                   surface_tag,
	input  wire logic                          wr_en,
	input  wire logic [ftc_pkg::IDX_W-1:0]     wr_index,
	input  wire logic [ftc_pkg::CFG_W-1:0]     wr_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [62:0]                        out_vertex_a,
	output logic [62:0]                        out_vertex_b,
	output logic [62:0]                        out_vertex_c,
	output logic [31:0]                        out_texcoord_a,
	output logic [31:0]                        out_texcoord_b,
	output logic [31:0]                        out_texcoord_c,
	output logic [5:0]                         out_edge_flags,
	output logic [15:0]                        out_surface_tag,
	output logic                               last_piece,
	output logic                               none_visible
);

	localparam int CNT_W = $clog2(MAX_PIECES + 1);
	localparam int SP_W  = $clog2(ftc_pkg::PLANE_COUNT + 1);

	typedef enum logic [14:0] {
		S_IDLE   = 15'h0001,
		S_PLANE  = 15'h0002,
		S_DOT    = 15'h0004,
		S_DWAIT  = 15'h0008,
		S_CLASS  = 15'h0010,
		S_CSET   = 15'h0020,
		S_CSET2  = 15'h0040,
		S_MLO    = 15'h0080,
		S_MHI    = 15'h0100,
		S_MACC   = 15'h0200,
		S_DIV    = 15'h0400,
		S_BUILD  = 15'h0800,
		S_EMIT   = 15'h1000,
		S_POP    = 15'h2000,
		S_FINISH = 15'h4000
	} state_t;

	function automatic logic signed [ftc_pkg::COORD_W-1:0] comp_get(
		input ftc_pkg::vtx_t v, input logic [2:0] i);
		logic signed [ftc_pkg::COORD_W-1:0] r;
		case (i)
			ftc_pkg::VAL_X: r = v.x;
			ftc_pkg::VAL_Y: r = v.y;
			ftc_pkg::VAL_Z: r = v.z;
			ftc_pkg::VAL_U: r = {{(ftc_pkg::COORD_W-ftc_pkg::UV_W){v.u[ftc_pkg::UV_W-1]}}, v.u};
			ftc_pkg::VAL_V: r = {{(ftc_pkg::COORD_W-ftc_pkg::UV_W){v.v[ftc_pkg::UV_W-1]}}, v.v};
			default:        r = '0;
		endcase
		return r;
	endfunction

	function automatic ftc_pkg::vtx_t comp_set(input ftc_pkg::vtx_t v,
		input logic [2:0] i, input logic signed [ftc_pkg::COORD_W-1:0] d);
		ftc_pkg::vtx_t r;
		r = v;
		case (i)
			ftc_pkg::VAL_X: r.x = d;
			ftc_pkg::VAL_Y: r.y = d;
			ftc_pkg::VAL_Z: r.z = d;
			ftc_pkg::VAL_U: r.u = d[ftc_pkg::UV_W-1:0];
			ftc_pkg::VAL_V: r.v = d[ftc_pkg::UV_W-1:0];
			default:        r = v;
		endcase
		return r;
	endfunction

	function automatic ftc_pkg::vtx_t unpack_vtx(input logic [62:0] p, input logic [31:0] t);
		ftc_pkg::vtx_t r;
		r.x = p[20:0];
		r.y = p[41:21];
		r.z = p[62:42];
		r.u = t[15:0];
		r.v = t[31:16];
		return r;
	endfunction

	// configuration
	logic [ftc_pkg::CFG_W-1:0]  near_q, far_q;
	logic [ftc_pkg::TRIG_W-1:0] vcos_q, vsin_q, hcos_q, hsin_q;

	// control
	state_t          state_q;
	logic [SP_W-1:0] sp_q;
	logic [CNT_W-1:0] count_q;
	logic            hold_q;
	logic            out_valid_q;
	logic            cut_sel_q;
	logic [2:0]      val_q;
	logic [1:0]      v_q, c_q;
	logic            pval_q;

	// datapath
	ftc_pkg::tri_t                         cur_q;
	ftc_pkg::tri_t                         stack_q [ftc_pkg::PLANE_COUNT];
	logic signed [ftc_pkg::DOT_W-1:0]      dot_q [3];
	logic signed [ftc_pkg::DOT_W-1:0]      acc_q;
	logic signed [ftc_pkg::MUL_P_W-1:0]    mul_q;
	logic [1:0]                            pv_q, pc_q;
	logic [2:0]                            code_q;
	ftc_pkg::vtx_t                         pvtx_q, qvtx_q;
	ftc_pkg::vtx_t                         cut_q [2];
	logic signed [ftc_pkg::DOT_W-1:0]      num_q, den_q;
	logic [ftc_pkg::PROD_W-1:0]            prod_lo_q;
	logic [15:0]                           tag_q;
	logic [62:0]                           ova_q, ovb_q, ovc_q;
	logic [31:0]                           ota_q, otb_q, otc_q;
	logic [5:0]                            oedge_q;
	logic [15:0]                           otag_q;
	logic                                  last_q, none_q;

	// combinational
	logic signed [ftc_pkg::NORM_W-1:0]     nrm;
	logic signed [ftc_pkg::DOT_W-1:0]      d_pl;
	logic [2:0]                            code;
	logic                                  a12, b12;
	logic [1:0]                            p_idx, q_idx, vsel;
	ftc_pkg::vtx_t                         sel_vtx;
	logic signed [ftc_pkg::DOT_W-1:0]      sel_dot;
	logic signed [ftc_pkg::COORD_W-1:0]    coord, pc_val, qc_val;
	logic signed [ftc_pkg::COORD_W:0]      diff;
	logic [ftc_pkg::COORD_W-1:0]           absdiff;
	logic [ftc_pkg::MAG_W-1:0]             numabs, denabs;
	logic                                  neg, den_zero;
	logic signed [ftc_pkg::MUL_A_W-1:0]    mul_a;
	logic signed [ftc_pkg::MUL_B_W-1:0]    mul_b;
	logic signed [ftc_pkg::DOT_W-1:0]      acc_n;
	logic [ftc_pkg::PROD_W-1:0]            dividend;
	logic [ftc_pkg::QUO_W-1:0]             quo;
	logic                                  div_done;
	logic signed [ftc_pkg::COORD_W+1:0]    sq, res_w;
	logic signed [ftc_pkg::COORD_W-1:0]    res;
	ftc_pkg::tri_t                         first_t, second_t;
	logic                                  two;

	// plane normal component for c_q and plane offset
	always_comb begin
		nrm  = '0;
		d_pl = '0;
		unique case (cur_q.plane)
			ftc_pkg::PL_NEAR: begin
				if (c_q == 2'd2) nrm = ftc_pkg::NORMAL_ONE;
				d_pl = $signed({5'b0, near_q, 15'b0});
			end
			ftc_pkg::PL_FAR: begin
				if (c_q == 2'd2) nrm = -ftc_pkg::NORMAL_ONE;
				d_pl = -$signed({5'b0, far_q, 15'b0});
			end
			ftc_pkg::PL_TOP: begin
				if (c_q == 2'd1) nrm = -$signed({1'b0, vcos_q});
				if (c_q == 2'd2) nrm = $signed({1'b0, vsin_q});
			end
			ftc_pkg::PL_BOTTOM: begin
				if (c_q == 2'd1) nrm = $signed({1'b0, vcos_q});
				if (c_q == 2'd2) nrm = $signed({1'b0, vsin_q});
			end
			ftc_pkg::PL_LEFT: begin
				if (c_q == 2'd0) nrm = $signed({1'b0, hcos_q});
				if (c_q == 2'd2) nrm = $signed({1'b0, hsin_q});
			end
			ftc_pkg::PL_RIGHT: begin
				if (c_q == 2'd0) nrm = -$signed({1'b0, hcos_q});
				if (c_q == 2'd2) nrm = $signed({1'b0, hsin_q});
			end
			default: begin
				nrm  = '0;
				d_pl = '0;
			end
		endcase
	end

	assign code = {dot_q[2] >= d_pl, dot_q[1] >= d_pl, dot_q[0] >= d_pl};

	// cut edges: first cut is b->c for codes AB and C, else a->b;
	// second cut is b->c for codes AC and B, else a->c
	assign a12   = (code_q == ftc_pkg::CODE_AB) || (code_q == ftc_pkg::CODE_C);
	assign b12   = (code_q == ftc_pkg::CODE_AC) || (code_q == ftc_pkg::CODE_B);
	assign p_idx = cut_sel_q ? (b12 ? 2'd1 : 2'd0) : (a12 ? 2'd1 : 2'd0);
	assign q_idx = cut_sel_q ? 2'd2 : (a12 ? 2'd2 : 2'd1);

	assign vsel    = (state_q == S_DOT) ? v_q : ((state_q == S_CSET) ? p_idx : q_idx);
	assign sel_vtx = cur_q.v[vsel];
	assign sel_dot = dot_q[vsel];
	assign coord   = comp_get(sel_vtx, {1'b0, c_q});

	assign pc_val  = comp_get(pvtx_q, val_q);
	assign qc_val  = comp_get(qvtx_q, val_q);
	assign diff    = {qc_val[ftc_pkg::COORD_W-1], qc_val} - {pc_val[ftc_pkg::COORD_W-1], pc_val};
	assign absdiff = diff[ftc_pkg::COORD_W] ? ftc_pkg::COORD_W'(-diff)
	                                        : diff[ftc_pkg::COORD_W-1:0];
	assign numabs  = num_q[ftc_pkg::DOT_W-1] ? ftc_pkg::MAG_W'(-num_q) : num_q[ftc_pkg::MAG_W-1:0];
	assign denabs  = den_q[ftc_pkg::DOT_W-1] ? ftc_pkg::MAG_W'(-den_q) : den_q[ftc_pkg::MAG_W-1:0];
	assign neg      = diff[ftc_pkg::COORD_W] ^ num_q[ftc_pkg::DOT_W-1] ^ den_q[ftc_pkg::DOT_W-1];
	assign den_zero = (den_q == '0);

	always_comb begin
		if (state_q == S_DOT) begin
			mul_a = {{2{coord[ftc_pkg::COORD_W-1]}}, coord};
			mul_b = {{(ftc_pkg::MUL_B_W-ftc_pkg::NORM_W){nrm[ftc_pkg::NORM_W-1]}}, nrm};
		end else if (state_q == S_MHI) begin
			mul_a = {2'b0, absdiff};
			mul_b = {2'b0, numabs[ftc_pkg::MAG_W-1:ftc_pkg::NUM_LO_W]};
		end else begin
			mul_a = {2'b0, absdiff};
			mul_b = {1'b0, numabs[ftc_pkg::NUM_LO_W-1:0]};
		end
	end

	assign acc_n = (pc_q == 2'd0) ? mul_q[ftc_pkg::DOT_W-1:0]
	                              : acc_q + mul_q[ftc_pkg::DOT_W-1:0];

	assign dividend = prod_lo_q + {mul_q[ftc_pkg::DOT_W-1:0], {ftc_pkg::NUM_LO_W{1'b0}}};

	ftc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_MACC),
		.dividend (dividend),
		.divisor  (denabs),
		.quotient (quo),
		.done     (div_done)
	);

	assign sq    = neg ? -$signed({2'b0, quo[ftc_pkg::QUO_W-2:0]}) : $signed({2'b0, quo[ftc_pkg::QUO_W-2:0]});
	assign res_w = {{2{pc_val[ftc_pkg::COORD_W-1]}}, pc_val} + sq;
	assign res   = res_w[ftc_pkg::COORD_W-1:0];

	// split or shrink the current triangle with the two crossing points
	always_comb begin
		first_t  = cur_q;
		second_t = cur_q;
		two      = 1'b0;
		case (code_q)
			ftc_pkg::CODE_AB: begin
				first_t.v[2]    = cut_q[0];
				first_t.edges   = cur_q.edges & (ftc_pkg::EDGE_AB | ftc_pkg::EDGE_BC);
				second_t.v[1]   = cut_q[0];
				second_t.v[2]   = cut_q[1];
				second_t.edges  = cur_q.edges & ftc_pkg::EDGE_CA;
				two             = 1'b1;
			end
			ftc_pkg::CODE_AC: begin
				first_t.v[1]    = cut_q[0];
				first_t.edges   = cur_q.edges & (ftc_pkg::EDGE_AB | ftc_pkg::EDGE_CA);
				second_t.v[0]   = cut_q[0];
				second_t.v[1]   = cut_q[1];
				second_t.edges  = cur_q.edges & ftc_pkg::EDGE_BC;
				two             = 1'b1;
			end
			ftc_pkg::CODE_BC: begin
				first_t.v[0]    = cut_q[0];
				first_t.edges   = cur_q.edges & (ftc_pkg::EDGE_AB | ftc_pkg::EDGE_BC);
				second_t.v[0]   = cut_q[1];
				second_t.v[1]   = cut_q[0];
				second_t.edges  = cur_q.edges & ftc_pkg::EDGE_CA;
				two             = 1'b1;
			end
			ftc_pkg::CODE_A: begin
				first_t.v[1]    = cut_q[0];
				first_t.v[2]    = cut_q[1];
				first_t.edges   = cur_q.edges & (ftc_pkg::EDGE_AB | ftc_pkg::EDGE_CA);
			end
			ftc_pkg::CODE_B: begin
				first_t.v[0]    = cut_q[0];
				first_t.v[2]    = cut_q[1];
				first_t.edges   = cur_q.edges & (ftc_pkg::EDGE_AB | ftc_pkg::EDGE_BC);
			end
			ftc_pkg::CODE_C: begin
				first_t.v[0]    = cut_q[1];
				first_t.v[1]    = cut_q[0];
				first_t.edges   = cur_q.edges & (ftc_pkg::EDGE_BC | ftc_pkg::EDGE_CA);
			end
			default: begin
				first_t = cur_q;
			end
		endcase
		first_t.plane  = cur_q.plane + ftc_pkg::PLANE_W'(1);
		second_t.plane = cur_q.plane + ftc_pkg::PLANE_W'(1);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= 20'd102;
			far_q  <= 20'd262144;
			vcos_q <= 16'd23170;
			vsin_q <= 16'd23170;
			hcos_q <= 16'd23170;
			hsin_q <= 16'd23170;
		end else if (wr_en) begin
			unique case (wr_index)
				ftc_pkg::REG_NEAR: near_q <= wr_data;
				ftc_pkg::REG_FAR:  far_q  <= wr_data;
				ftc_pkg::REG_VCOS: vcos_q <= wr_data[ftc_pkg::TRIG_W-1:0];
				ftc_pkg::REG_VSIN: vsin_q <= wr_data[ftc_pkg::TRIG_W-1:0];
				ftc_pkg::REG_HCOS: hcos_q <= wr_data[ftc_pkg::TRIG_W-1:0];
				ftc_pkg::REG_HSIN: hsin_q <= wr_data[ftc_pkg::TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			count_q     <= '0;
			hold_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cut_sel_q   <= 1'b0;
			val_q       <= '0;
			v_q         <= '0;
			c_q         <= '0;
			pval_q      <= 1'b0;
		end else begin
			pval_q <= (state_q == S_DOT);
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					sp_q    <= '0;
					count_q <= '0;
					state_q <= S_PLANE;
				end
				S_PLANE: if (cur_q.plane == ftc_pkg::PLANE_W'(ftc_pkg::PLANE_COUNT)) begin
					state_q <= S_EMIT;
				end else begin
					v_q     <= '0;
					c_q     <= '0;
					state_q <= S_DOT;
				end
				S_DOT: begin
					if (c_q == 2'd2) begin
						c_q <= '0;
						v_q <= v_q + 2'd1;
					end else begin
						c_q <= c_q + 2'd1;
					end
					if (v_q == 2'd2 && c_q == 2'd2) state_q <= S_DWAIT;
				end
				S_DWAIT: state_q <= S_CLASS;
				S_CLASS: begin
					if (code == ftc_pkg::CODE_ALL) begin
						state_q <= S_PLANE;
					end else if (code == ftc_pkg::CODE_NONE) begin
						state_q <= S_POP;
					end else begin
						cut_sel_q <= 1'b0;
						state_q   <= S_CSET;
					end
				end
				S_CSET:  state_q <= S_CSET2;
				S_CSET2: begin
					val_q   <= ftc_pkg::VAL_X;
					state_q <= S_MLO;
				end
				S_MLO, S_DIV: begin
					if ((state_q == S_MLO && den_zero) || (state_q == S_DIV && div_done)) begin
						if (val_q == ftc_pkg::VAL_V) begin
							if (cut_sel_q) begin
								state_q <= S_BUILD;
							end else begin
								cut_sel_q <= 1'b1;
								state_q   <= S_CSET;
							end
						end else begin
							val_q   <= val_q + 3'd1;
							state_q <= S_MLO;
						end
					end else if (state_q == S_MLO) begin
						state_q <= S_MHI;
					end
				end
				S_MHI:  state_q <= S_MACC;
				S_MACC: state_q <= S_DIV;
				S_BUILD: begin
					if (two) sp_q <= sp_q + SP_W'(1);
					state_q <= S_PLANE;
				end
				S_EMIT: if (!out_valid_q) begin
					if (hold_q) begin
						// release the piece held back, it is not the last
						out_valid_q <= 1'b1;
						hold_q      <= 1'b0;
					end else begin
						hold_q  <= 1'b1;
						count_q <= count_q + CNT_W'(1);
						state_q <= (count_q == CNT_W'(MAX_PIECES - 1)) ? S_FINISH : S_POP;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						sp_q    <= sp_q - SP_W'(1);
						state_q <= S_PLANE;
					end
				end
				S_FINISH: if (!out_valid_q) begin
					hold_q      <= 1'b0;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		pv_q  <= v_q;
		pc_q  <= c_q;
		if (pval_q) begin
			acc_q <= acc_n;
			if (pc_q == 2'd2) dot_q[pv_q] <= acc_n;
		end
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cur_q.v[0]  <= unpack_vtx(vertex_a, texcoord_a);
				cur_q.v[1]  <= unpack_vtx(vertex_b, texcoord_b);
				cur_q.v[2]  <= unpack_vtx(vertex_c, texcoord_c);
				cur_q.edges <= edge_flags;
				cur_q.plane <= ftc_pkg::PL_NEAR;
				tag_q       <= surface_tag;
			end
			S_CLASS: begin
				code_q <= code;
				if (code == ftc_pkg::CODE_ALL) cur_q.plane <= cur_q.plane + ftc_pkg::PLANE_W'(1);
			end
			S_CSET: begin
				pvtx_q <= sel_vtx;
				num_q  <= d_pl - sel_dot;
			end
			S_CSET2: begin
				qvtx_q <= sel_vtx;
				den_q  <= sel_dot - d_pl + num_q;
			end
			S_MLO: if (den_zero) begin
				cut_q[cut_sel_q] <= comp_set(cut_q[cut_sel_q], val_q, pc_val);
			end
			S_MHI: prod_lo_q <= ftc_pkg::PROD_W'(mul_q[ftc_pkg::DOT_W:0]);
			S_DIV: if (div_done) begin
				cut_q[cut_sel_q] <= comp_set(cut_q[cut_sel_q], val_q, res);
			end
			S_BUILD: begin
				cur_q <= first_t;
				if (two) stack_q[sp_q] <= second_t;
			end
			S_EMIT: if (!out_valid_q) begin
				if (hold_q) begin
					last_q <= 1'b0;
				end else begin
					ova_q   <= {cur_q.v[0].z, cur_q.v[0].y, cur_q.v[0].x};
					ovb_q   <= {cur_q.v[1].z, cur_q.v[1].y, cur_q.v[1].x};
					ovc_q   <= {cur_q.v[2].z, cur_q.v[2].y, cur_q.v[2].x};
					ota_q   <= {cur_q.v[0].v, cur_q.v[0].u};
					otb_q   <= {cur_q.v[1].v, cur_q.v[1].u};
					otc_q   <= {cur_q.v[2].v, cur_q.v[2].u};
					oedge_q <= cur_q.edges;
					otag_q  <= tag_q;
					none_q  <= 1'b0;
				end
			end
			S_POP: if (sp_q != '0) cur_q <= stack_q[sp_q - SP_W'(1)];
			S_FINISH: if (!out_valid_q) begin
				last_q <= 1'b1;
				if (!hold_q) begin
					ova_q   <= '0;
					ovb_q   <= '0;
					ovc_q   <= '0;
					ota_q   <= '0;
					otb_q   <= '0;
					otc_q   <= '0;
					oedge_q <= '0;
					otag_q  <= '0;
					none_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign out_vertex_a    = ova_q;
	assign out_vertex_b    = ovb_q;
	assign out_vertex_c    = ovc_q;
	assign out_texcoord_a  = ota_q;
	assign out_texcoord_b  = otb_q;
	assign out_texcoord_c  = otc_q;
	assign out_edge_flags  = oedge_q;
	assign out_surface_tag = otag_q;
	assign last_piece      = last_q;
	assign none_visible    = none_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(ftc_pkg::PLANE_COUNT))
		else $error("pending stack overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PIECES))
		else $error("piece count beyond limit");

	a_hold_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hold_q && out_valid_q))
		else $error("held piece while output beat pending");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EMIT || $past(state_q) == S_FINISH))
		else $error("output beat raised from wrong state");

endmodule
`default_nettype wire

[tb/sv/frustum_triangle_clipper_core_tb.sv]
// Testbench for frustum_triangle_clipper_core: random and directed triangles, clipped
// pieces predicted in-bench and compared beat by beat. Depends on ftc_pkg and the core.
`timescale 1ns / 100ps
`default_nettype none
module frustum_triangle_clipper_core_tb;

	localparam int MAXP = 64;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		logic [62:0] va, vb, vc;
		logic [31:0] ta, tb, tc;
		logic [5:0]  edges;
		logic [15:0] tag;
	} tri_item_t;

	typedef struct {
		logic [62:0] va, vb, vc;
		logic [31:0] ta, tb, tc;
		logic [5:0]  edges;
		logic [15:0] tag;
		logic        last, none;
	} piece_t;

	typedef struct {
		longint p[3][3];
		longint uv[3][2];
		logic [5:0] edges;
	} geo_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [62:0] vertex_a = 0, vertex_b = 0, vertex_c = 0;
	logic [31:0] texcoord_a = 0, texcoord_b = 0, texcoord_c = 0;
	logic [5:0] edge_flags = 0;
	logic [15:0] surface_tag = 0;
	logic wr_en = 0;
	logic [ftc_pkg::IDX_W-1:0] wr_index = 0;
	logic [ftc_pkg::CFG_W-1:0] wr_data = 0;
	logic [62:0] out_vertex_a, out_vertex_b, out_vertex_c;
	logic [31:0] out_texcoord_a, out_texcoord_b, out_texcoord_c;
	logic [5:0] out_edge_flags;
	logic [15:0] out_surface_tag;
	logic last_piece, none_visible;

	frustum_triangle_clipper_core u_top (.*);

	// configuration copy
	longint near_d = 102, far_d = 262144, vcos = 23170, vsin = 23170;
	longint hcos = 23170, hsin = 23170;
	longint pn[6][3];
	longint pd[6];

	tri_item_t pending_tris[$];
	piece_t expected_pieces[$];
	piece_t piece_buf[$];
	int errors = 0;
	int stall_cycles = 0;
	bit hold_send = 0;
	bit in_acc = 0;

	initial forever #5 clk = ~clk;

	function automatic longint sx(logic [63:0] v, int bits);
		longint r;
		r = longint'(v & ((64'd1 << bits) - 1));
		if (r[bits-1]) r = r - (longint'(1) << bits);
		return r;
	endfunction

	function automatic longint dot_at(int k, longint v[3]);
		return pn[k][0] * v[0] + pn[k][1] * v[1] + pn[k][2] * v[2];
	endfunction

	task automatic crossing(int k, geo_t t, int a, int b, output longint pt[3],
			output longint uv[2]);
		longint da, num, den;
		da = dot_at(k, t.p[a]);
		num = pd[k] - da;
		den = dot_at(k, t.p[b]) - da;
		for (int i = 0; i < 3; i++)
			pt[i] = (den == 0) ? t.p[a][i] : t.p[a][i] + (t.p[b][i] - t.p[a][i]) * num / den;
		for (int i = 0; i < 2; i++)
			uv[i] = (den == 0) ? t.uv[a][i] : t.uv[a][i] + (t.uv[b][i] - t.uv[a][i]) * num / den;
	endtask

	function automatic logic [62:0] pack_v(longint p[3]);
		return {p[2][20:0], p[1][20:0], p[0][20:0]};
	endfunction

	task automatic emit_piece(geo_t t, logic [15:0] tag);
		piece_t r;
		if (piece_buf.size() >= MAXP) return;
		r.va = pack_v(t.p[0]);
		r.vb = pack_v(t.p[1]);
		r.vc = pack_v(t.p[2]);
		r.ta = {t.uv[0][1][15:0], t.uv[0][0][15:0]};
		r.tb = {t.uv[1][1][15:0], t.uv[1][0][15:0]};
		r.tc = {t.uv[2][1][15:0], t.uv[2][0][15:0]};
		r.edges = t.edges;
		r.tag = tag;
		r.last = 0;
		r.none = 0;
		piece_buf.push_back(r);
	endtask

	task automatic set_corner(ref geo_t t, input int i, input longint pt[3], input longint uv[2]);
		for (int c = 0; c < 3; c++) t.p[i][c] = pt[c];
		t.uv[i][0] = uv[0];
		t.uv[i][1] = uv[1];
	endtask

	task automatic clip_plane(int k, geo_t t, logic [15:0] tag);
		logic [2:0] code;
		longint a[3], b[3], ua[2], ub[2];
		geo_t f;
		if (k >= ftc_pkg::PLANE_COUNT) begin
			emit_piece(t, tag);
			return;
		end
		for (int i = 0; i < 3; i++) code[i] = dot_at(k, t.p[i]) >= pd[k];
		f = t;
		case (code)
			ftc_pkg::CODE_ALL: clip_plane(k + 1, t, tag);
			ftc_pkg::CODE_AB: begin
				crossing(k, t, 1, 2, a, ua);
				crossing(k, t, 0, 2, b, ub);
				set_corner(f, 2, a, ua);
				f.edges &= ftc_pkg::EDGE_AB | ftc_pkg::EDGE_BC;
				clip_plane(k + 1, f, tag);
				set_corner(t, 1, a, ua);
				set_corner(t, 2, b, ub);
				t.edges &= ftc_pkg::EDGE_CA;
				clip_plane(k + 1, t, tag);
			end
			ftc_pkg::CODE_AC: begin
				crossing(k, t, 0, 1, a, ua);
				crossing(k, t, 1, 2, b, ub);
				set_corner(f, 1, a, ua);
				f.edges &= ftc_pkg::EDGE_AB | ftc_pkg::EDGE_CA;
				clip_plane(k + 1, f, tag);
				set_corner(t, 0, a, ua);
				set_corner(t, 1, b, ub);
				t.edges &= ftc_pkg::EDGE_BC;
				clip_plane(k + 1, t, tag);
			end
			ftc_pkg::CODE_BC: begin
				crossing(k, t, 0, 1, a, ua);
				crossing(k, t, 0, 2, b, ub);
				set_corner(f, 0, a, ua);
				f.edges &= ftc_pkg::EDGE_AB | ftc_pkg::EDGE_BC;
				clip_plane(k + 1, f, tag);
				set_corner(t, 0, b, ub);
				set_corner(t, 1, a, ua);
				t.edges &= ftc_pkg::EDGE_CA;
				clip_plane(k + 1, t, tag);
			end
			ftc_pkg::CODE_A: begin
				crossing(k, t, 0, 1, a, ua);
				crossing(k, t, 0, 2, b, ub);
				set_corner(t, 1, a, ua);
				set_corner(t, 2, b, ub);
				t.edges &= ftc_pkg::EDGE_AB | ftc_pkg::EDGE_CA;
				clip_plane(k + 1, t, tag);
			end
			ftc_pkg::CODE_B: begin
				crossing(k, t, 0, 1, a, ua);
				crossing(k, t, 1, 2, b, ub);
				set_corner(t, 0, a, ua);
				set_corner(t, 2, b, ub);
				t.edges &= ftc_pkg::EDGE_AB | ftc_pkg::EDGE_BC;
				clip_plane(k + 1, t, tag);
			end
			ftc_pkg::CODE_C: begin
				crossing(k, t, 1, 2, a, ua);
				crossing(k, t, 0, 2, b, ub);
				set_corner(t, 0, b, ub);
				set_corner(t, 1, a, ua);
				t.edges &= ftc_pkg::EDGE_BC | ftc_pkg::EDGE_CA;
				clip_plane(k + 1, t, tag);
			end
			default: ;
		endcase
	endtask

	task automatic predict_pieces(tri_item_t it);
		geo_t t;
		logic [62:0] vv[3];
		logic [31:0] tt[3];
		piece_t z;
		pn[ftc_pkg::PL_NEAR] = '{0, 0, 32768};     pd[ftc_pkg::PL_NEAR] = near_d << 15;
		pn[ftc_pkg::PL_FAR] = '{0, 0, -32768};     pd[ftc_pkg::PL_FAR] = -(far_d << 15);
		pn[ftc_pkg::PL_TOP] = '{0, -vcos, vsin};   pd[ftc_pkg::PL_TOP] = 0;
		pn[ftc_pkg::PL_BOTTOM] = '{0, vcos, vsin}; pd[ftc_pkg::PL_BOTTOM] = 0;
		pn[ftc_pkg::PL_LEFT] = '{hcos, 0, hsin};   pd[ftc_pkg::PL_LEFT] = 0;
		pn[ftc_pkg::PL_RIGHT] = '{-hcos, 0, hsin}; pd[ftc_pkg::PL_RIGHT] = 0;
		vv = '{it.va, it.vb, it.vc};
		tt = '{it.ta, it.tb, it.tc};
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 3; c++) t.p[i][c] = sx(vv[i] >> (21 * c), 21);
			t.uv[i][0] = sx(tt[i], 16);
			t.uv[i][1] = sx(tt[i] >> 16, 16);
		end
		t.edges = it.edges;
		piece_buf.delete();
		clip_plane(0, t, it.tag);
		if (piece_buf.size() == 0) begin
			z = '{default: '0};
			z.last = 1;
			z.none = 1;
			piece_buf.push_back(z);
		end
		piece_buf[piece_buf.size() - 1].last = 1;
		foreach (piece_buf[i]) expected_pieces.push_back(piece_buf[i]);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic logic [62:0] pack_xyz(int x, int y, int z);
		return {z[20:0], y[20:0], x[20:0]};
	endfunction

	function automatic tri_item_t rand_tri(bit wide);
		tri_item_t t;
		int r;
		logic [62:0] vv[3];
		for (int i = 0; i < 3; i++) begin
			if (wide) vv[i] = {$urandom, $urandom};
			else begin
				// mostly a plausible view volume so cuts and splits happen
				r = 4096;
				vv[i] = pack_xyz($urandom_range(0, 2 * r) - r, $urandom_range(0, 2 * r) - r,
					$urandom_range(0, 3 * r) - 200);
			end
		end
		t.va = vv[0]; t.vb = vv[1]; t.vc = vv[2];
		t.ta = $urandom; t.tb = $urandom; t.tc = $urandom;
		t.edges = $urandom;
		t.tag = $urandom;
		return t;
	endfunction

	function automatic tri_item_t make_tri(logic [62:0] a, logic [62:0] b, logic [62:0] c,
			logic [31:0] uv, logic [5:0] e);
		tri_item_t t;
		t.va = a; t.vb = b; t.vc = c;
		t.ta = uv; t.tb = ~uv; t.tc = {uv[15:0], uv[31:16]};
		t.edges = e;
		t.tag = {uv[7:0], ~uv[7:0]};
		return t;
	endfunction

	// driver: bursts and gaps; payload moves only after an accepted beat or while in_valid is low
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		if (in_acc) begin
			predict_pieces(pending_tris.pop_front());
		end
		if (in_acc || !in_valid) begin
			if (gap_left > 0) gap_left--;
			if (!hold_send && pending_tris.size() > 0 && gap_left == 0) begin
				vertex_a <= pending_tris[0].va;
				vertex_b <= pending_tris[0].vb;
				vertex_c <= pending_tris[0].vc;
				texcoord_a <= pending_tris[0].ta;
				texcoord_b <= pending_tris[0].tb;
				texcoord_c <= pending_tris[0].tc;
				edge_flags <= pending_tris[0].edges;
				surface_tag <= pending_tris[0].tag;
				in_valid <= 1;
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(0, 6);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
				end
			end else
				in_valid <= 0;
		end
	end

	// receiver stall pattern
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase[9]) out_ready <= 1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// monitor
	always @(posedge clk) begin
		piece_t e;
		in_acc <= arst_n && in_valid && in_ready;
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
		else stall_cycles++;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pieces.size() == 0) report_mismatch("unexpected beat", 0, 0);
			else begin
				e = expected_pieces.pop_front();
				if (none_visible !== e.none) report_mismatch("none_visible", none_visible, e.none);
				if (last_piece !== e.last) report_mismatch("last_piece", last_piece, e.last);
				if (!e.none) begin
					if (out_vertex_a !== e.va) report_mismatch("out_vertex_a", out_vertex_a, e.va);
					if (out_vertex_b !== e.vb) report_mismatch("out_vertex_b", out_vertex_b, e.vb);
					if (out_vertex_c !== e.vc) report_mismatch("out_vertex_c", out_vertex_c, e.vc);
					if (out_texcoord_a !== e.ta)
						report_mismatch("out_texcoord_a", out_texcoord_a, e.ta);
					if (out_texcoord_b !== e.tb)
						report_mismatch("out_texcoord_b", out_texcoord_b, e.tb);
					if (out_texcoord_c !== e.tc)
						report_mismatch("out_texcoord_c", out_texcoord_c, e.tc);
					if (out_edge_flags !== e.edges)
						report_mismatch("out_edge_flags", out_edge_flags, e.edges);
					if (out_surface_tag !== e.tag)
						report_mismatch("out_surface_tag", out_surface_tag, e.tag);
				end
			end
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", stall_cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_tris.size() > 0 || in_valid || expected_pieces.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [ftc_pkg::IDX_W-1:0] idx, logic [ftc_pkg::CFG_W-1:0] val);
		@(negedge clk);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			ftc_pkg::REG_NEAR: near_d = val;
			ftc_pkg::REG_FAR:  far_d = val;
			ftc_pkg::REG_VCOS: vcos = val[15:0];
			ftc_pkg::REG_VSIN: vsin = val[15:0];
			ftc_pkg::REG_HCOS: hcos = val[15:0];
			ftc_pkg::REG_HSIN: hsin = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 0;
	endtask

	task automatic write_all(logic [19:0] n, logic [19:0] f, logic [15:0] vc_, logic [15:0] vs_,
			logic [15:0] hc_, logic [15:0] hs_);
		write_reg(ftc_pkg::REG_NEAR, n);
		write_reg(ftc_pkg::REG_FAR, f);
		write_reg(ftc_pkg::REG_VCOS, vc_);
		write_reg(ftc_pkg::REG_VSIN, vs_);
		write_reg(ftc_pkg::REG_HCOS, hc_);
		write_reg(ftc_pkg::REG_HSIN, hs_);
		write_reg(3'd7, 20'hABCDE);  // unused index, must be ignored
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed: inside, outside, one/two inside, extremes
		pending_tris.push_back(make_tri(pack_xyz(0, 0, 2048), pack_xyz(100, 0, 2048),
			pack_xyz(0, 100, 2048), 32'h1234_5678, 6'h3F));
		pending_tris.push_back(make_tri(pack_xyz(0, 0, -5), pack_xyz(1, 0, -5),
			pack_xyz(0, 1, -5), 32'h8000_7FFF, 6'h15));
		pending_tris.push_back(make_tri(pack_xyz(0, 0, 2048), pack_xyz(0, 0, 0),
			pack_xyz(10, 0, 0), 32'hFFFF_0000, 6'h3F));
		pending_tris.push_back(make_tri(pack_xyz(0, 0, 2048), pack_xyz(5, 0, 2000),
			pack_xyz(10, 0, 0), 32'h0000_FFFF, 6'h2A));
		pending_tris.push_back(make_tri(pack_xyz(-3000, -3000, 1000),
			pack_xyz(3000, -3000, 1000), pack_xyz(0, 3000, 1000), 32'h7FFF_8000, 6'h07));
		pending_tris.push_back(make_tri(pack_xyz(-900000, -900000, 1048575),
			pack_xyz(900000, 0, 5), pack_xyz(0, 900000, 300000), 32'hAAAA_5555, 6'h38));
		pending_tris.push_back(make_tri(63'h7FFF_FFFF_FFFF_FFFF, 63'h0,
			pack_xyz(-1048576, 1048575, 100), 32'h5555_AAAA, 6'h00));
		pending_tris.push_back(make_tri(pack_xyz(1048575, -1048576, 1048575),
			pack_xyz(-1048576, 1048575, 1048575), pack_xyz(0, 0, -1048576), 32'hFFFF_FFFF, 6'h3F));
		wait_drained();
		write_all(0, 1048575, 32768, 32768, 32768, 32768);
		for (int i = 0; i < 12; i++) pending_tris.push_back(rand_tri(i[0]));
		wait_drained();
		write_all(1048575, 0, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++) pending_tris.push_back(rand_tri(i[0]));
		wait_drained();
		write_all(102, 262144, 23170, 23170, 23170, 23170);
		for (int i = 0; i < 110; i++) pending_tris.push_back(rand_tri($urandom_range(0, 4) == 0));
		wait_drained();
		write_all($urandom_range(0, 600), $urandom_range(2000, 8000), $urandom_range(0, 32768),
			$urandom_range(0, 32768), $urandom_range(0, 32768), 16'hFFFF);
		for (int i = 0; i < 60; i++) pending_tris.push_back(rand_tri($urandom_range(0, 4) == 0));
		// pause until drained, then resume
		while (pending_tris.size() > 30) @(posedge clk);
		hold_send = 1;
		while (in_valid || expected_pieces.size() > 0) @(posedge clk);
		hold_send = 0;
		wait_drained();
		write_all(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < 60; i++) pending_tris.push_back(rand_tri(i[0]));
		wait_drained();
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
hdl/ftc_pkg.sv
hdl/ftc_divider.sv
hdl/frustum_triangle_clipper_core.sv
tb/sv/frustum_triangle_clipper_core_tb.sv
